// File: rtl/core/ccc_pkg.sv
package ccc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEPT_BITS = 2'd1;

  localparam logic [3:0] KEPT_BITS_RESET = 4'd7;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_PARTIAL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_COMP    = 2'd1,
    KIND_DECOMP  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] k;
    logic [7:0] data;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic clear;
  } ctrl_t;

endpackage

// File: rtl/core/ccc_fifo.sv
module ccc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/ccc_front.sv
module ccc_front
  import ccc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  last_in_i,
  output entry_t                entry_o,
  output ctrl_t                 ctrl_o
);

  logic       dir_q, dir_d;
  logic [3:0] kept_q, kept_d;
  logic       clear;

  always_comb begin
    dir_d  = dir_q;
    kept_d = kept_q;
    clear  = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DIRECTION: begin
          dir_d = cfg_wdata_i[0];
          clear = 1'b1;
        end
        REG_KEPT_BITS: begin
          kept_d = cfg_wdata_i;
          clear  = 1'b1;
        end
        default: begin
          clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= 1'b0;
      kept_q <= KEPT_BITS_RESET;
    end else begin
      dir_q  <= dir_d;
      kept_q <= kept_d;
    end
  end

  assign ctrl_o.clear = clear;

  always_comb begin
    entry_o.k    = kept_q;
    entry_o.last = last_in_i;
    if (!(kept_q inside {4'd7, 4'd4, 4'd3})) begin
      entry_o.kind = KIND_INVALID;
      entry_o.data = '0;
    end else if (dir_q) begin
      entry_o.kind = KIND_DECOMP;
      entry_o.data = in_byte_i;
    end else begin
      entry_o.kind = KIND_COMP;
      entry_o.data = in_byte_i >> (4'd8 - kept_q);
    end
  end

endmodule

// File: rtl/core/ccc_back.sv
module ccc_back
  import ccc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_t      ctrl_i,
  input  logic       head_valid_i,
  output logic       head_ready_o,
  input  entry_t     head_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic [1:0] status_o
);

  logic        busy_q, busy_d;
  logic [14:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [1:0]  n_q, n_d;
  logic        last_q;
  kind_e       kind_q;
  logic [3:0]  k_q;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  status_e     status_q;

  logic [14:0] a, a2, na;
  logic [3:0]  c, c2, nc, k, step;
  logic [1:0]  n, n2, nn;
  logic        l;
  kind_e       kind;
  logic        active, can, more, emit, done, clr, slot_ok, go, load_out;
  logic [7:0]  field8, coef, ob;
  logic        ol;
  status_e     os;

  assign head_ready_o = !busy_q;
  assign active       = busy_q || head_valid_i;
  assign slot_ok      = !out_valid_q || out_ready_i;

  always_comb begin
    if (busy_q) begin
      a    = acc_q;
      c    = cnt_q;
      n    = n_q;
      l    = last_q;
      kind = kind_q;
      k    = k_q;
    end else begin
      n    = '0;
      l    = head_i.last;
      kind = head_i.kind;
      k    = head_i.k;
      if (head_i.kind == KIND_INVALID) begin
        a = acc_q;
        c = cnt_q;
      end else begin
        a = acc_q | (15'(head_i.data) << cnt_q);
        c = cnt_q + ((head_i.kind == KIND_DECOMP) ? 4'd8 : head_i.k);
      end
    end
  end

  always_comb begin
    step   = (kind == KIND_DECOMP) ? k : 4'd8;
    can    = (kind == KIND_COMP) ? ((c >= 4'd8) && (n == 2'd0))
                                 : ((c >= k) && (n != 2'd3));
    a2     = a >> step;
    c2     = c - step;
    n2     = n + 2'd1;
    more   = (kind == KIND_DECOMP) && (c2 >= k) && (n2 != 2'd3);
    field8 = a[7:0] & ((8'd1 << k) - 8'd1);
    coef   = (field8 << (4'd8 - k)) | (8'd1 << (4'd7 - k));
  end

  always_comb begin
    emit = 1'b0;
    done = 1'b0;
    clr  = 1'b0;
    ob   = '0;
    ol   = 1'b0;
    os   = ST_OK;
    na   = a;
    nc   = c;
    nn   = n;
    case (kind)
      KIND_INVALID: begin
        emit = 1'b1;
        os   = ST_INVALID;
        ol   = l;
        done = 1'b1;
      end
      default: begin
        if (can) begin
          emit = 1'b1;
          ob   = (kind == KIND_DECOMP) ? coef : a[7:0];
          na   = a2;
          nc   = c2;
          nn   = n2;
          if (!more) begin
            if (!l) begin
              done = 1'b1;
            end else if (c2 == 4'd0) begin
              done = 1'b1;
              clr  = 1'b1;
              ol   = 1'b1;
            end
          end
        end else if (l && (c != 4'd0)) begin
          emit = 1'b1;
          os   = ST_PARTIAL;
          ol   = 1'b1;
          done = 1'b1;
          clr  = 1'b1;
        end else begin
          done = 1'b1;
          clr  = l;
        end
      end
    endcase
  end

  assign go       = active && (!emit || slot_ok);
  assign load_out = go && emit;

  always_comb begin
    busy_d = busy_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    n_d    = n;
    if (ctrl_i.clear) begin
      busy_d = 1'b0;
      acc_d  = '0;
      cnt_d  = '0;
    end else if (active) begin
      if (!go) begin
        busy_d = 1'b1;
        acc_d  = a;
        cnt_d  = c;
      end else if (done) begin
        busy_d = 1'b0;
        acc_d  = clr ? '0 : na;
        cnt_d  = clr ? '0 : nc;
      end else begin
        busy_d = 1'b1;
        acc_d  = na;
        cnt_d  = nc;
        n_d    = nn;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    last_q <= l;
    kind_q <= kind;
    k_q    <= k;
    if (load_out) begin
      out_byte_q <= ob;
      out_last_q <= ol;
      status_q   <= os;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign status_o    = status_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 4'd15)
    else $error("bit count out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q != ST_OK) |-> out_byte_q == 8'd0)
    else $error("non-ok result carries data");

  a_partial_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == ST_PARTIAL) |-> out_last_q)
    else $error("partial-group result not marked last");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> (cnt_q == 4'd0) && !busy_q)
    else $error("register write did not clear the accumulator");

endmodule

// File: rtl/core/coefficient_compress_codec_top.sv
// With the back end idle, an accepted request is written into the queue, and its first result
// is then loaded from the queue head into the result register.
// Throughput: at most one result per cycle while the output is not stalled; a compress request
// yields at most one result, a decompress request one per restored coefficient (up to three),
// plus a partial-group result at the end of a vector; a four-entry queue absorbs the stalls.
// Reset (rst_ni low, asynchronous) sets direction 0, kept_bits 7 and empties all state.
module coefficient_compress_codec_top
  import ccc_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            in_byte_i,
  input  logic                  last_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  out_last_o,
  output logic [1:0]            status_o
);

  entry_t front_entry, head_entry;
  ctrl_t  ctrl;
  logic   head_valid, head_ready;

  ccc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_byte_i   (in_byte_i),
    .last_in_i   (last_in_i),
    .entry_o     (front_entry),
    .ctrl_o      (ctrl)
  );

  ccc_fifo #(
    .Width ($bits(entry_t)),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (front_entry),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_ready),
    .pop_data_o   (head_entry)
  );

  ccc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .head_valid_i (head_valid),
    .head_ready_o (head_ready),
    .head_i       (head_entry),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .status_o     (status_o)
  );

endmodule
